// ===== hw/rtl/cipd_pkg.sv =====
// Shared types, opcode constants and target helpers for the instruction predecoder.
package cipd_pkg;

  localparam int unsigned AddrBits = 16;
  localparam int unsigned WordBits = 10;
  localparam int unsigned BankBits = 4;

  // Two-word misc opcode (ldi) and the pt= form that leaves carry clear.
  localparam logic [WordBits-1:0] OPC_LDI        = 10'h130;
  localparam logic [WordBits-1:0] OPC_PT_LOAD    = 10'h3d4;

  // Misc sub-opcodes, taken from word bits 5:2.
  localparam logic [3:0] MISC_TEST_A     = 4'h3;
  localparam logic [3:0] MISC_TEST_B     = 4'hb;
  localparam logic [3:0] MISC_PT_GROUP   = 4'h5;
  localparam logic [3:0] MISC_RET_GROUP  = 4'h8;
  localparam logic [3:0] MISC_SELPF      = 4'h9;

  // Two-bit class codes in the low bits of the first word.
  localparam logic [1:0] LOW_LONG_BRANCH = 2'd1;

  typedef enum logic [2:0] {
    CLS_MISC          = 3'd0,
    CLS_LONG_BRANCH   = 3'd1,
    CLS_ARITH         = 3'd2,
    CLS_SHORT_BRANCH  = 3'd3,
    CLS_SELECT_FOLLOW = 3'd4
  } inst_class_t;

  typedef enum logic [2:0] {
    FLOW_NONE        = 3'd0,
    FLOW_UNCOND      = 3'd1,
    FLOW_COND        = 3'd2,
    FLOW_CALL        = 3'd3,
    FLOW_RETURN      = 3'd4,
    FLOW_COND_RETURN = 3'd5
  } flow_t;

  typedef enum logic [2:0] {
    FORM_NONE  = 3'd0,
    FORM_PLAIN = 3'd1,
    FORM_HEX   = 3'd2,
    FORM_PAGE0 = 3'd3,
    FORM_PAGE1 = 3'd4,
    FORM_PAGE2 = 3'd5,
    FORM_PAGE3 = 3'd6
  } form_t;

  typedef struct packed {
    form_t form;
    logic  is_call;
  } special_t;

  // Grouped instruction handed from the front end to the decoder.
  typedef struct packed {
    logic [AddrBits-1:0] addr;
    logic [WordBits-1:0] w1;
    logic [WordBits-1:0] w2;
    logic [WordBits-1:0] w3;
    logic [1:0]          count;
    logic                sel_follow;
    logic [BankBits-1:0] bank;
    logic [AddrBits-1:0] after;
  } rec_t;

  // One decoded instruction as presented on the result channel.
  typedef struct packed {
    logic [AddrBits-1:0] inst_address;
    logic [WordBits-1:0] word_one;
    logic [WordBits-1:0] word_two;
    logic [WordBits-1:0] word_three;
    logic [1:0]          word_count;
    inst_class_t         inst_class;
    flow_t               flow_kind;
    logic [AddrBits-1:0] target_address;
    logic [BankBits-1:0] target_bank;
    form_t               extended_form;
    logic                carry_clear_after;
  } res_t;

  // Sixteen-bit target of a long branch.
  function automatic logic [AddrBits-1:0] long_target(input logic [WordBits-1:0] w1,
                                                      input logic [WordBits-1:0] w2);
    return {w2[9:2], w1[9:2]};
  endfunction

  // Special long-call entry points that become three-word jumps.
  function automatic special_t special_form(input logic [AddrBits-1:0] tgt);
    special_t s;
    s.form    = FORM_NONE;
    s.is_call = 1'b0;
    case (tgt)
      16'h0fd9: begin s.form = FORM_HEX;   s.is_call = 1'b0; end
      16'h0fda: begin s.form = FORM_PLAIN; s.is_call = 1'b0; end
      16'h0fdd: begin s.form = FORM_HEX;   s.is_call = 1'b1; end
      16'h0fde: begin s.form = FORM_PLAIN; s.is_call = 1'b1; end
      16'h23d0: begin s.form = FORM_PAGE0; s.is_call = 1'b0; end
      16'h23d2: begin s.form = FORM_PAGE0; s.is_call = 1'b1; end
      16'h23d9: begin s.form = FORM_PAGE1; s.is_call = 1'b0; end
      16'h23db: begin s.form = FORM_PAGE1; s.is_call = 1'b1; end
      16'h23e2: begin s.form = FORM_PAGE2; s.is_call = 1'b0; end
      16'h23e4: begin s.form = FORM_PAGE2; s.is_call = 1'b1; end
      16'h23eb: begin s.form = FORM_PAGE3; s.is_call = 1'b0; end
      16'h23ed: begin s.form = FORM_PAGE3; s.is_call = 1'b1; end
      default: begin s.form = FORM_NONE; s.is_call = 1'b0; end
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/cipd_front.sv =====
// Front end: counts word addresses and groups program words into instructions.
module cipd_front #(
  parameter int unsigned ADDRESS_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [9:0]              rom_word,
  input  logic [3:0]              code_bank,
  input  logic                    restart,
  input  logic [15:0]             start_address,
  input  logic                    ext_enable,
  output logic                    push,
  output cipd_pkg::rec_t          push_rec
);
  import cipd_pkg::*;

  logic [ADDRESS_WIDTH-1:0] next_address_r, next_address_nxt;
  logic [ADDRESS_WIDTH-1:0] first_addr_r, first_addr_nxt;
  logic [WordBits-1:0]      held0_r, held0_nxt;
  logic [WordBits-1:0]      held1_r, held1_nxt;
  logic [1:0]               held_cnt_r, held_cnt_nxt;
  logic                     sel_pend_r, sel_pend_nxt;

  logic [ADDRESS_WIDTH-1:0] here;
  logic [1:0]               held_cnt;
  logic                     sel_pend;
  logic                     take_third;
  special_t                 sp;

  // Word address, partial-instruction state and the select follow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_address_r <= '0;
      first_addr_r   <= '0;
      held_cnt_r     <= 2'd0;
      sel_pend_r     <= 1'b0;
    end else begin
      next_address_r <= next_address_nxt;
      first_addr_r   <= first_addr_nxt;
      held_cnt_r     <= held_cnt_nxt;
      sel_pend_r     <= sel_pend_nxt;
    end
  end

  // Held words are only read after they have been written.
  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

  // A restart drops any partial instruction and any pending select word.
  always_comb begin
    here     = restart ? start_address[ADDRESS_WIDTH-1:0] : next_address_r;
    held_cnt = restart ? 2'd0 : held_cnt_r;
    sel_pend = restart ? 1'b0 : sel_pend_r;
    sp       = special_form(long_target(held0_r, rom_word));
    take_third = ext_enable && (held0_r[1:0] == LOW_LONG_BRANCH) && !rom_word[1] &&
                 (sp.form != FORM_NONE);
  end

  // Grouping of words into one-, two- and three-word instructions.
  always_comb begin
    next_address_nxt = next_address_r;
    first_addr_nxt   = first_addr_r;
    held0_nxt        = held0_r;
    held1_nxt        = held1_r;
    held_cnt_nxt     = held_cnt_r;
    sel_pend_nxt     = sel_pend_r;
    push             = 1'b0;
    push_rec.addr       = AddrBits'(first_addr_r);
    push_rec.w1         = held0_r;
    push_rec.w2         = '0;
    push_rec.w3         = '0;
    push_rec.count      = 2'd1;
    push_rec.sel_follow = 1'b0;
    push_rec.bank       = code_bank;
    push_rec.after      = AddrBits'(here + ADDRESS_WIDTH'(1));

    if (accept) begin
      next_address_nxt = here + ADDRESS_WIDTH'(1);
      sel_pend_nxt     = sel_pend;
      held_cnt_nxt     = 2'd0;
      if (held_cnt == 2'd1) begin
        if (take_third) begin
          held1_nxt    = rom_word;
          held_cnt_nxt = 2'd2;
        end else begin
          push           = 1'b1;
          push_rec.w2    = rom_word;
          push_rec.count = 2'd2;
        end
      end else if (held_cnt == 2'd2) begin
        push           = 1'b1;
        push_rec.w2    = held1_r;
        push_rec.w3    = rom_word;
        push_rec.count = 2'd3;
      end else begin
        first_addr_nxt = here;
        push_rec.addr  = AddrBits'(here);
        push_rec.w1    = rom_word;
        if (sel_pend) begin
          push                = 1'b1;
          push_rec.sel_follow = 1'b1;
          if (rom_word[0]) begin
            sel_pend_nxt = 1'b0;
          end
        end else if ((rom_word[1:0] == LOW_LONG_BRANCH) || (rom_word == OPC_LDI)) begin
          held0_nxt    = rom_word;
          held_cnt_nxt = 2'd1;
        end else begin
          push = 1'b1;
          // selpf arms the follow-on word.
          if ((rom_word[1:0] == 2'd0) && (rom_word[5:2] == MISC_SELPF)) begin
            sel_pend_nxt = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/cipd_queue.sv =====
// Two-entry queue of grouped instructions between the front end and the decoder.
module cipd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cipd_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output cipd_pkg::rec_t head
);
  import cipd_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rec_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== hw/rtl/cipd_back.sv =====
// Back end: decodes queued instructions, tracks carry and holds the result register.
module cipd_back #(
  parameter int unsigned ADDRESS_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rec_valid,
  input  cipd_pkg::rec_t rec,
  output logic           rec_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output cipd_pkg::res_t res
);
  import cipd_pkg::*;

  localparam logic [AddrBits-1:0] AddrMask = AddrBits'((17'd1 << ADDRESS_WIDTH) - 17'd1);

  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;
  logic        carry_clear_r, carry_clear_nxt;
  res_t        dec;
  logic        clear_after;
  logic        cond_c, is_call, uncond;
  special_t    sp;
  logic [2:0]  page_code;
  logic [ADDRESS_WIDTH-1:0] short_tgt;
  logic [AddrBits-1:0]      tgt;

  assign rec_pop   = rec_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  // Instruction decode against the current carry knowledge.
  always_comb begin
    clear_after = 1'b1;
    cond_c      = 1'b0;
    is_call     = 1'b0;
    uncond      = 1'b0;
    sp          = special_form(long_target(rec.w1, rec.w2));
    page_code   = 3'(sp.form) - 3'(FORM_PAGE0);
    short_tgt   = rec.addr[ADDRESS_WIDTH-1:0] +
                  ADDRESS_WIDTH'(signed'(rec.w1[9:3]));
    tgt         = '0;

    dec.inst_address      = rec.addr;
    dec.word_one          = rec.w1;
    dec.word_two          = rec.w2;
    dec.word_three        = rec.w3;
    dec.word_count        = rec.count;
    dec.inst_class        = inst_class_t'({1'b0, rec.w1[1:0]});
    dec.flow_kind         = FLOW_NONE;
    dec.target_address    = '0;
    dec.target_bank       = '0;
    dec.extended_form     = FORM_NONE;
    dec.carry_clear_after = 1'b1;

    if (rec.sel_follow) begin
      dec.inst_class = CLS_SELECT_FOLLOW;
    end else begin
      case (dec.inst_class)
        CLS_MISC: begin
          case (rec.w1[5:2])
            MISC_TEST_A, MISC_TEST_B: begin
              clear_after = 1'b0;
            end
            MISC_PT_GROUP: begin
              if (rec.w1 != OPC_PT_LOAD) begin
                clear_after = 1'b0;
              end
            end
            MISC_RET_GROUP: begin
              if (rec.w1[9:6] inside {4'd4, 4'd5}) begin
                clear_after = 1'b0;
              end
              if (rec.w1[9:6] inside {4'd13, 4'd14}) begin
                dec.flow_kind = FLOW_COND_RETURN;
              end else if (rec.w1[9:6] == 4'd15) begin
                dec.flow_kind = FLOW_RETURN;
              end
            end
            default: begin
            end
          endcase
        end
        CLS_ARITH: begin
          if (rec.w1[9:5] inside {[5'd9:5'd27]}) begin
            clear_after = 1'b0;
          end
        end
        CLS_SHORT_BRANCH: begin
          dec.target_address = AddrBits'(short_tgt);
          dec.target_bank    = rec.bank;
          dec.flow_kind      = (!rec.w1[2] && carry_clear_r) ? FLOW_UNCOND : FLOW_COND;
        end
        CLS_LONG_BRANCH: begin
          cond_c  = rec.w2[0];
          is_call = !rec.w2[1];
          uncond  = !cond_c && carry_clear_r;
          tgt     = long_target(rec.w1, rec.w2);
          if (rec.count == 2'd3) begin
            dec.extended_form = sp.form;
            is_call           = sp.is_call;
            if ((sp.form == FORM_PLAIN) || (sp.form == FORM_HEX)) begin
              tgt = {rec.after[15:10], rec.w3};
            end else begin
              tgt = {rec.after[15:12], page_code[1:0], rec.w3};
            end
          end
          dec.target_address = tgt & AddrMask;
          dec.target_bank    = rec.bank;
          dec.flow_kind      = is_call ? FLOW_CALL : (uncond ? FLOW_UNCOND : FLOW_COND);
        end
        default: begin
        end
      endcase
    end
    dec.carry_clear_after = clear_after;
  end

  // Carry knowledge and output register handshake.
  always_comb begin
    carry_clear_nxt = carry_clear_r;
    out_valid_nxt   = out_valid_r && !res_ready;
    if (rec_pop) begin
      carry_clear_nxt = clear_after;
      out_valid_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      carry_clear_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      carry_clear_r <= carry_clear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_res_r <= dec;
    end
  end

endmodule

// ===== hw/rtl/calculator_cpu_instruction_predecoder_core.sv =====
// Top level of the instruction predecoder: config register, front end, queue and decoder.
//
//   channel  direction  handshake            carries
//   in_      input      in_valid/in_ready    one program word with bank and restart
//   out_     output     out_valid/out_ready  one decoded instruction
//   cfg      input      APB write/read       extended jump enable at byte address 0
//
// One program word is accepted per cycle while the queue has room; a finished instruction
// is written into the queue as its last word is taken and then reaches the output register.
// The front end and the decoder are parted by a two-entry queue, and the decoder
// feeds an output register, so a stall on out_ready backs up into in_ready only
// once the queue is full. Reset clears the address counter, grouping and carry state.
module calculator_cpu_instruction_predecoder_core #(
  parameter int unsigned ADDRESS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Program word channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_rom_word,
  input  logic [3:0]  in_code_bank,
  input  logic        in_restart,
  input  logic [15:0] in_start_address,
  // Decoded instruction channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_inst_address,
  output logic [9:0]  out_word_one,
  output logic [9:0]  out_word_two,
  output logic [9:0]  out_word_three,
  output logic [1:0]  out_word_count,
  output logic [2:0]  out_inst_class,
  output logic [2:0]  out_flow_kind,
  output logic [15:0] out_target_address,
  output logic [3:0]  out_target_bank,
  output logic [2:0]  out_extended_form,
  output logic        out_carry_clear_after,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cipd_pkg::*;

  logic ext_enable_r, ext_enable_nxt;
  logic reg0_sel;
  logic in_accept;
  logic push, q_full, q_valid, q_pop;
  rec_t push_rec, q_head;
  res_t res;

  // Configuration register.
  assign pready   = 1'b1;
  assign reg0_sel = (paddr[2] == 1'b0);
  assign prdata   = {31'd0, ext_enable_r & reg0_sel};

  always_comb begin
    ext_enable_nxt = ext_enable_r;
    if (psel && penable && pwrite && pready && reg0_sel) begin
      ext_enable_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_enable_r <= 1'b0;
    end else begin
      ext_enable_r <= ext_enable_nxt;
    end
  end

  // Input request is taken whenever the queue has room.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  cipd_front #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .rom_word     (in_rom_word),
    .code_bank    (in_code_bank),
    .restart      (in_restart),
    .start_address(in_start_address),
    .ext_enable   (ext_enable_r),
    .push         (push),
    .push_rec     (push_rec)
  );

  cipd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  cipd_back #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_valid(q_valid),
    .rec      (q_head),
    .rec_pop  (q_pop),
    .res_valid(out_valid),
    .res_ready(out_ready),
    .res      (res)
  );

  // Result request fields.
  assign out_inst_address      = res.inst_address;
  assign out_word_one          = res.word_one;
  assign out_word_two          = res.word_two;
  assign out_word_three        = res.word_three;
  assign out_word_count        = res.word_count;
  assign out_inst_class        = res.inst_class;
  assign out_flow_kind         = res.flow_kind;
  assign out_target_address    = res.target_address;
  assign out_target_bank       = res.target_bank;
  assign out_extended_form     = res.extended_form;
  assign out_carry_clear_after = res.carry_clear_after;

endmodule
